// ===== sv/serial_lcd_bus_snooper_unit_assert.svh =====
`ifndef SERIAL_LCD_BUS_SNOOPER_UNIT_ASSERT_SVH
`define SERIAL_LCD_BUS_SNOOPER_UNIT_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SLBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("snooper assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define SLBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("snooper assertion failed");

`endif

// ===== sv/slbs_pkg.sv =====
package slbs_pkg;

  localparam int STORE_DEPTH = 50;
  localparam int BURST_LIMIT = 1024;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int WP_W    = (STORE_DEPTH > 127) ? 8 : 7;
  localparam int BURST_W = $clog2(BURST_LIMIT + 1);

  localparam logic [7:0] DATA_PREFIX = 8'h5F;
  localparam logic [7:0] CMD_PREFIX  = 8'h1F;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_ONOFF   = 8'h08;
  localparam logic [7:0] ONOFF_MASK  = 8'hF8;
  localparam logic [7:0] FILL_CHAR   = 8'h20;

  localparam logic [7:0] SRC_CHAR_1  = 8'h81;
  localparam logic [7:0] SRC_CHAR_2  = 8'h82;
  localparam logic [7:0] SRC_CHAR_3  = 8'h83;
  localparam logic [7:0] SRC_CHAR_OPT = 8'h6C;
  localparam logic [7:0] SRC_CHAR_COAX = 8'h20;

  localparam logic [2:0] SRC_UNKNOWN = 3'd0;
  localparam logic [2:0] SRC_DIRECT1 = 3'd1;
  localparam logic [2:0] SRC_DIRECT2 = 3'd2;
  localparam logic [2:0] SRC_DIRECT3 = 3'd3;
  localparam logic [2:0] SRC_OPTICAL = 3'd4;
  localparam logic [2:0] SRC_COAXIAL = 3'd5;

  localparam logic [1:0] SCREEN_OTHER  = 2'd0;
  localparam logic [1:0] SCREEN_VOLUME = 2'd1;
  localparam logic [1:0] SCREEN_INPUT  = 2'd2;

  localparam logic [5:0] VOLUME_RESET = 6'd50;

  localparam int VTAG_BASE = 7;
  localparam int VSUM_BASE = 20;
  localparam int ITAG_BASE = 0;
  localparam int ISRC_BASE = 14;
  localparam int TAG_LEN   = 6;
  localparam int VSUM_LEN  = 20;

  typedef struct packed {
    logic       op;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic       display_on;
    logic [5:0] volume_level;
    logic [2:0] input_source;
    logic [1:0] screen_kind;
  } out_item_t;

  function automatic logic [7:0] vol_tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h56;
      3'd1: ch = 8'h6F;
      3'd2: ch = 8'h6C;
      3'd3: ch = 8'h75;
      3'd4: ch = 8'h6D;
      3'd5: ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] inp_tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h49;
      3'd1: ch = 8'h6E;
      3'd2: ch = 8'h70;
      3'd3: ch = 8'h75;
      3'd4: ch = 8'h74;
      3'd5: ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/serial_lcd_bus_snooper_unit.sv =====
// A bus byte is accepted in S_IDLE, then parsed in S_BYTE, which also does any store write.
// At an end of burst the scan checks the volume tag, then the volume bars or the input tag,
// then the input source, reading the character store one entry per cycle.
// The scan result waits in S_REPORT, with the input stalled, until the output register drains.
// Reset is asynchronous and active low; the store reads as zeros straight after reset,
// as each entry carries a valid bit that reset clears, so no clearing pass is needed.
`include "serial_lcd_bus_snooper_unit_assert.svh"

module serial_lcd_bus_snooper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slbs_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slbs_pkg::out_item_t out_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_BYTE   = 7'b0000010,
    S_VTAG   = 7'b0000100,
    S_VSUM   = 7'b0001000,
    S_ITAG   = 7'b0010000,
    S_ISRC   = 7'b0100000,
    S_REPORT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] store_mem [slbs_pkg::STORE_DEPTH];
  logic [slbs_pkg::STORE_DEPTH-1:0] ok_q, ok_d;
  logic [7:0] fill_q, fill_d;

  logic [slbs_pkg::BURST_W-1:0] burst_q, burst_d;
  logic [1:0] phase_q, phase_d;
  logic       prefix_q, prefix_d;
  logic [7:0] low_q, low_d;
  logic       dmode_q, dmode_d;
  logic [slbs_pkg::WP_W-1:0] wp_q, wp_d;
  logic       power_q, power_d;
  logic [5:0] volume_q, volume_d;
  logic [2:0] source_q, source_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] byte_q, byte_d;

  logic [4:0] cnt_q, cnt_d;
  logic       match_q, match_d;
  logic [5:0] acc_q, acc_d;

  logic                      out_valid_q, out_valid_d;
  slbs_pkg::out_item_t       out_q, out_d;

  logic [slbs_pkg::ADDR_W-1:0] base_addr, rd_addr;
  logic [7:0]  rd_data_q;
  logic        rd_ok_q;
  logic [7:0]  elem;
  logic [2:0]  tag_idx;
  logic [1:0]  score;
  logic [7:0]  cmd_val;
  logic        wr_en;
  logic [slbs_pkg::ADDR_W-1:0] wr_addr;
  logic        in_acc, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign elem    = rd_ok_q ? rd_data_q : fill_q;
  assign tag_idx = 3'(cnt_q - 5'd1);
  assign score   = (elem == 8'h00) ? 2'd1 : ((elem == 8'h01) ? 2'd2 : 2'd0);
  assign cmd_val = {byte_q[3:0], 4'b0000} + low_q;
  assign wr_addr = wp_q[slbs_pkg::ADDR_W-1:0];

  always_comb begin
    case (state_q)
      S_VTAG:  base_addr = slbs_pkg::ADDR_W'(slbs_pkg::VTAG_BASE);
      S_VSUM:  base_addr = slbs_pkg::ADDR_W'(slbs_pkg::VSUM_BASE);
      S_ISRC:  base_addr = slbs_pkg::ADDR_W'(slbs_pkg::ISRC_BASE);
      default: base_addr = slbs_pkg::ADDR_W'(slbs_pkg::ITAG_BASE);
    endcase
  end
  assign rd_addr = base_addr + slbs_pkg::ADDR_W'(cnt_q);

  always_comb begin
    state_d     = state_q;
    ok_d        = ok_q;
    fill_d      = fill_q;
    burst_d     = burst_q;
    phase_d     = phase_q;
    prefix_d    = prefix_q;
    low_d       = low_q;
    dmode_d     = dmode_q;
    wp_d        = wp_q;
    power_d     = power_q;
    volume_d    = volume_q;
    source_d    = source_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_i.op) begin
            if (burst_q < slbs_pkg::BURST_W'(slbs_pkg::BURST_LIMIT)) begin
              burst_d = burst_q + 1'b1;
              byte_d  = in_i.bus_byte;
              state_d = S_BYTE;
            end
          end else if (burst_q != '0) begin
            cnt_d   = '0;
            match_d = 1'b1;
            state_d = S_VTAG;
          end
        end
      end
      S_BYTE: begin
        state_d = S_IDLE;
        case (phase_q)
          2'd0: begin
            if (byte_q == slbs_pkg::DATA_PREFIX) begin
              prefix_d = 1'b1;
              phase_d  = 2'd1;
            end else if (byte_q == slbs_pkg::CMD_PREFIX) begin
              prefix_d = 1'b0;
              phase_d  = 2'd1;
            end
          end
          2'd1: begin
            low_d   = byte_q;
            phase_d = 2'd2;
          end
          default: begin
            phase_d = 2'd0;
            if (prefix_q) begin
              if (dmode_q && (wp_q < slbs_pkg::WP_W'(slbs_pkg::STORE_DEPTH))) begin
                wr_en         = 1'b1;
                ok_d[wr_addr] = 1'b1;
                wp_d          = wp_q + 1'b1;
              end
            end else if (cmd_val[7]) begin
              dmode_d = 1'b1;
              wp_d    = slbs_pkg::WP_W'(cmd_val[6:0]);
            end else if (cmd_val == slbs_pkg::CMD_CLEAR) begin
              ok_d    = '0;
              fill_d  = slbs_pkg::FILL_CHAR;
              dmode_d = 1'b1;
              wp_d    = '0;
            end else if ((cmd_val & slbs_pkg::ONOFF_MASK) == slbs_pkg::CMD_ONOFF) begin
              power_d = cmd_val[2];
              dmode_d = 1'b0;
            end else begin
              dmode_d = 1'b0;
            end
          end
        endcase
      end
      S_VTAG: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          match_d = match_q && (elem == slbs_pkg::vol_tag_char(tag_idx));
        end
        if (cnt_q == 5'(slbs_pkg::TAG_LEN)) begin
          cnt_d = '0;
          if (match_d) begin
            acc_d   = '0;
            state_d = S_VSUM;
          end else begin
            match_d = 1'b1;
            state_d = S_ITAG;
          end
        end
      end
      S_VSUM: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          acc_d = acc_q + 6'(score);
        end
        if (cnt_q == 5'(slbs_pkg::VSUM_LEN)) begin
          cnt_d    = '0;
          volume_d = acc_d;
          kind_d   = slbs_pkg::SCREEN_VOLUME;
          state_d  = S_REPORT;
        end
      end
      S_ITAG: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          match_d = match_q && (elem == slbs_pkg::inp_tag_char(tag_idx));
        end
        if (cnt_q == 5'(slbs_pkg::TAG_LEN)) begin
          cnt_d = '0;
          if (match_d) begin
            state_d = S_ISRC;
          end else begin
            kind_d  = slbs_pkg::SCREEN_OTHER;
            state_d = S_REPORT;
          end
        end
      end
      S_ISRC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          cnt_d   = '0;
          kind_d  = slbs_pkg::SCREEN_INPUT;
          state_d = S_REPORT;
          case (elem)
            slbs_pkg::SRC_CHAR_1:    source_d = slbs_pkg::SRC_DIRECT1;
            slbs_pkg::SRC_CHAR_2:    source_d = slbs_pkg::SRC_DIRECT2;
            slbs_pkg::SRC_CHAR_3:    source_d = slbs_pkg::SRC_DIRECT3;
            slbs_pkg::SRC_CHAR_OPT:  source_d = slbs_pkg::SRC_OPTICAL;
            slbs_pkg::SRC_CHAR_COAX: source_d = slbs_pkg::SRC_COAXIAL;
            default:                 source_d = source_q;
          endcase
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.display_on   = power_q;
          out_d.volume_level = volume_q;
          out_d.input_source = source_q;
          out_d.screen_kind  = kind_q;
          burst_d            = '0;
          phase_d            = 2'd0;
          prefix_d           = 1'b0;
          low_d              = '0;
          dmode_d            = 1'b0;
          wp_d               = '0;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ok_q        <= '0;
      fill_q      <= '0;
      burst_q     <= '0;
      phase_q     <= 2'd0;
      prefix_q    <= 1'b0;
      low_q       <= '0;
      dmode_q     <= 1'b0;
      wp_q        <= '0;
      power_q     <= 1'b1;
      volume_q    <= slbs_pkg::VOLUME_RESET;
      source_q    <= slbs_pkg::SRC_UNKNOWN;
      kind_q      <= slbs_pkg::SCREEN_OTHER;
      cnt_q       <= '0;
      match_q     <= 1'b1;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      fill_q      <= fill_d;
      burst_q     <= burst_d;
      phase_q     <= phase_d;
      prefix_q    <= prefix_d;
      low_q       <= low_d;
      dmode_q     <= dmode_d;
      wp_q        <= wp_d;
      power_q     <= power_d;
      volume_q    <= volume_d;
      source_q    <= source_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      match_q     <= match_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= cmd_val;
    end
    rd_data_q <= store_mem[rd_addr];
    rd_ok_q   <= ok_q[rd_addr];
  end

  `SLBS_ASSERT_NEXT(a_burst_end_starts_scan,
                    in_acc && in_i.op && (burst_q != '0), state_q == S_VTAG)
  `SLBS_ASSERT_NOW(a_burst_within_limit, 1'b1,
                   burst_q <= slbs_pkg::BURST_W'(slbs_pkg::BURST_LIMIT))
  `SLBS_ASSERT_NOW(a_sum_bounded, state_q == S_VSUM, acc_q <= {cnt_q, 1'b0})
  `SLBS_ASSERT_NEXT(a_report_clears_burst, (state_q == S_REPORT) && out_free,
                    out_valid_q && (state_q == S_IDLE) && (burst_q == '0) && !dmode_q)

endmodule

// ===== test/tb_serial_lcd_bus_snooper_unit.sv =====
module tb_serial_lcd_bus_snooper_unit;
  import slbs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_ITEMS_PER_STAGE = 60;

  localparam int STAGE_DIRECTED   = 0;
  localparam int STAGE_FREE       = 1;
  localparam int STAGE_SEND_IDLE  = 2;
  localparam int STAGE_RECV_STALL = 3;
  localparam int STAGE_BOTH       = 4;
  localparam int STAGE_HOLD       = 5;
  localparam int STAGE_LONG       = 6;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [47:0] VOLUME_TEXT = "Volume";
  localparam logic [47:0] INPUT_TEXT  = "Input:";

  localparam logic [7:0] CMD_SET_POS = 8'h80;

  typedef enum logic [1:0] {
    WAIT_START,
    WAIT_LOW,
    WAIT_HIGH
  } parse_state_e;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  serial_lcd_bus_snooper_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  in_item_t     bus_items[$];
  out_item_t    expected_reports[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           stage = STAGE_DIRECTED;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           items_made = 0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;

  logic [7:0]   shadow_store[STORE_DEPTH];
  int unsigned  shadow_burst;
  parse_state_e shadow_parse;
  logic         shadow_is_data;
  logic [7:0]   shadow_low;
  logic         shadow_data_mode;
  logic [6:0]   shadow_wpos;
  logic         shadow_power;
  logic [5:0]   shadow_volume;
  logic [2:0]   shadow_source;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic reset_shadow();
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;
    shadow_burst = 0;
    shadow_parse = WAIT_START;
    shadow_is_data = 1'b0;
    shadow_low = 8'h00;
    shadow_data_mode = 1'b0;
    shadow_wpos = '0;
    shadow_power = 1'b1;
    shadow_volume = VOLUME_RESET;
    shadow_source = SRC_UNKNOWN;
  endtask

  task automatic decode_command(input logic [7:0] c);
    if (c[7]) begin
      shadow_data_mode = 1'b1;
      shadow_wpos = c[6:0];
    end else if (c == CMD_CLEAR) begin
      for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = FILL_CHAR;
      shadow_data_mode = 1'b1;
      shadow_wpos = '0;
    end else if ((c & ONOFF_MASK) == CMD_ONOFF) begin
      shadow_power = c[2];
      shadow_data_mode = 1'b0;
    end else begin
      shadow_data_mode = 1'b0;
    end
  endtask

  task automatic parse_bus_byte(input logic [7:0] b);
    logic [7:0] c;
    case (shadow_parse)
      WAIT_START: begin
        if (b == DATA_PREFIX) begin
          shadow_is_data = 1'b1;
          shadow_parse = WAIT_LOW;
        end else if (b == CMD_PREFIX) begin
          shadow_is_data = 1'b0;
          shadow_parse = WAIT_LOW;
        end
      end
      WAIT_LOW: begin
        shadow_low = b;
        shadow_parse = WAIT_HIGH;
      end
      default: begin
        c = (b << 4) + shadow_low;
        shadow_parse = WAIT_START;
        if (shadow_is_data) begin
          if (shadow_data_mode && shadow_wpos < STORE_DEPTH) begin
            shadow_store[shadow_wpos] = c;
            shadow_wpos = shadow_wpos + 7'd1;
          end
        end else begin
          decode_command(c);
        end
      end
    endcase
  endtask

  task automatic finish_burst();
    out_item_t  report;
    logic       vol_hit;
    logic       inp_hit;
    int unsigned bar_sum;
    logic [1:0] kind;
    vol_hit = 1'b1;
    inp_hit = 1'b1;
    bar_sum = 0;
    kind = SCREEN_OTHER;
    for (int i = 0; i < TAG_LEN; i++) begin
      if (shadow_store[VTAG_BASE + i] != VOLUME_TEXT[47 - 8 * i -: 8]) vol_hit = 1'b0;
      if (shadow_store[ITAG_BASE + i] != INPUT_TEXT[47 - 8 * i -: 8]) inp_hit = 1'b0;
    end
    if (vol_hit) begin
      for (int i = VSUM_BASE; i < VSUM_BASE + VSUM_LEN; i++) begin
        if (shadow_store[i] == 8'h00) bar_sum += 1;
        if (shadow_store[i] == 8'h01) bar_sum += 2;
      end
      shadow_volume = bar_sum[5:0];
      kind = SCREEN_VOLUME;
    end else if (inp_hit) begin
      case (shadow_store[ISRC_BASE])
        SRC_CHAR_1:    shadow_source = SRC_DIRECT1;
        SRC_CHAR_2:    shadow_source = SRC_DIRECT2;
        SRC_CHAR_3:    shadow_source = SRC_DIRECT3;
        SRC_CHAR_OPT:  shadow_source = SRC_OPTICAL;
        SRC_CHAR_COAX: shadow_source = SRC_COAXIAL;
        default: ;
      endcase
      kind = SCREEN_INPUT;
    end
    shadow_burst = 0;
    shadow_parse = WAIT_START;
    shadow_is_data = 1'b0;
    shadow_low = 8'h00;
    shadow_data_mode = 1'b0;
    shadow_wpos = '0;
    report.display_on = shadow_power;
    report.volume_level = shadow_volume;
    report.input_source = shadow_source;
    report.screen_kind = kind;
    expected_reports.push_back(report);
  endtask

  task automatic snoop_track(input in_item_t it);
    if (it.op == OP_BYTE) begin
      if (shadow_burst < BURST_LIMIT) begin
        shadow_burst++;
        parse_bus_byte(it.bus_byte);
      end
    end else if (shadow_burst != 0) begin
      finish_burst();
    end
  endtask

  // Driver: the item on the bus is held until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) snoop_track(in_i);
      if (!in_valid_i || !in_stall_o) begin
        if (bus_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_i <= bus_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!hold_done && stage == STAGE_HOLD) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %h", $time, out_o);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("display_on", 8'(want.display_on), 8'(out_o.display_on));
        compare_field("volume_level", 8'(want.volume_level), 8'(out_o.volume_level));
        compare_field("input_source", 8'(want.input_source), 8'(out_o.input_source));
        compare_field("screen_kind", 8'(want.screen_kind), 8'(out_o.screen_kind));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    in_item_t it;
    it.op = op;
    it.bus_byte = b;
    bus_items.push_back(it);
    items_made++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(OP_BYTE, b);
  endtask

  task automatic push_end();
    push_item(OP_END, 8'($urandom));
  endtask

  // The upper nibble of the high byte is shifted out, so it is left random.
  task automatic push_triple(input logic [7:0] prefix, input logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] rest;
    lo = {4'($urandom), c[3:0]};
    rest = c - lo;
    push_byte(prefix);
    push_byte(lo);
    push_byte({4'($urandom), rest[7:4]});
  endtask

  task automatic push_text(input logic [47:0] text);
    for (int i = 0; i < TAG_LEN; i++) push_triple(DATA_PREFIX, text[47 - 8 * i -: 8]);
  endtask

  function automatic logic [7:0] random_command();
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return CMD_CLEAR;
      2: return CMD_ONOFF | 8'($urandom_range(0, 7));
      default: return CMD_SET_POS | 8'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic push_random_burst();
    logic [47:0] tag;
    logic [7:0]  ch;
    int          n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if ($urandom_range(0, 9) < 7) push_triple(CMD_PREFIX, CMD_CLEAR);
        push_triple(CMD_PREFIX, CMD_SET_POS | 8'(VTAG_BASE));
        tag = VOLUME_TEXT;
        if ($urandom_range(0, 9) < 2) tag[8 * $urandom_range(0, 5) +: 8] = 8'($urandom);
        push_text(tag);
        push_triple(CMD_PREFIX, CMD_SET_POS | 8'(VSUM_BASE));
        n = $urandom_range(0, VSUM_LEN);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: ch = 8'h00;
            1: ch = 8'h01;
            2: ch = FILL_CHAR;
            default: ch = 8'($urandom);
          endcase
          push_triple(DATA_PREFIX, ch);
        end
      end
      3, 4, 5: begin
        if ($urandom_range(0, 9) < 7) push_triple(CMD_PREFIX, CMD_CLEAR);
        else push_triple(CMD_PREFIX, CMD_SET_POS | 8'(ITAG_BASE));
        tag = INPUT_TEXT;
        if ($urandom_range(0, 9) < 2) tag[8 * $urandom_range(0, 5) +: 8] = 8'($urandom);
        push_text(tag);
        push_triple(CMD_PREFIX, CMD_SET_POS | 8'(ISRC_BASE));
        case ($urandom_range(0, 5))
          0: ch = SRC_CHAR_1;
          1: ch = SRC_CHAR_2;
          2: ch = SRC_CHAR_3;
          3: ch = SRC_CHAR_OPT;
          4: ch = SRC_CHAR_COAX;
          default: ch = 8'($urandom);
        endcase
        push_triple(DATA_PREFIX, ch);
      end
      6, 7: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1)) push_triple(CMD_PREFIX, random_command());
          else push_triple(DATA_PREFIX, 8'($urandom));
        end
      end
      8: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) push_byte(8'($urandom));
      end
      default: begin
        push_triple(CMD_PREFIX, CMD_ONOFF | 8'($urandom_range(0, 7)));
        if ($urandom_range(0, 1)) push_end();
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      push_byte($urandom_range(0, 1) ? DATA_PREFIX : CMD_PREFIX);
      if ($urandom_range(0, 1)) push_byte(8'($urandom));
    end
    push_end();
  endtask

  task automatic wait_for_drain();
    while (bus_items.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random_stage(input int id, input int send_pct, input int recv_pct);
    stage = id;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    items_made = 0;
    while (items_made < RANDOM_ITEMS_PER_STAGE) push_random_burst();
    wait_for_drain();
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    stage = STAGE_DIRECTED;
    push_end();
    push_byte(8'hFF);
    push_byte(8'h00);
    push_triple(CMD_PREFIX, CMD_ONOFF);
    push_triple(DATA_PREFIX, 8'h41);
    push_triple(CMD_PREFIX, CMD_SET_POS | 8'(STORE_DEPTH - 1));
    push_triple(DATA_PREFIX, 8'hFF);
    push_triple(DATA_PREFIX, 8'h00);
    push_byte(CMD_PREFIX);
    push_byte(8'h12);
    push_end();
    push_end();
    push_triple(CMD_PREFIX, 8'h0F);
    push_end();
    wait_for_drain();

    run_random_stage(STAGE_FREE, 0, 0);
    run_random_stage(STAGE_SEND_IDLE, 71, 0);
    run_random_stage(STAGE_RECV_STALL, 0, 71);
    run_random_stage(STAGE_BOTH, 10, 10);

    // Many short bursts while the receiver holds off, so the block backs up.
    stage = STAGE_HOLD;
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 30; i++) begin
      push_byte(8'($urandom));
      push_end();
    end
    wait_for_drain();

    // Bytes beyond the burst limit, including the source character, must be dropped.
    stage = STAGE_LONG;
    push_triple(CMD_PREFIX, CMD_CLEAR);
    push_text(INPUT_TEXT);
    for (int i = 3 + 3 * TAG_LEN; i < BURST_LIMIT; i++) push_byte(8'h00);
    push_triple(CMD_PREFIX, CMD_SET_POS | 8'(ISRC_BASE));
    push_triple(DATA_PREFIX, SRC_CHAR_1);
    push_end();
    wait_for_drain();

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== serial_lcd_bus_snooper_unit.f =====
+incdir+sv
sv/slbs_pkg.sv
sv/serial_lcd_bus_snooper_unit.sv
test/tb_serial_lcd_bus_snooper_unit.sv
